FILE: src/cvb_pkg.sv
// Shared types and widths for the camera view basis pipeline.
package cvb_pkg;

    localparam int CVB_CW       = 32;               // coordinate width, Q16.16
    localparam int CVB_F        = 15;               // unit vector fraction bits
    localparam int CVB_OW       = CVB_F + 1;        // unit vector field width
    localparam int CVB_MW       = CVB_CW;           // magnitude of a difference
    localparam int CVB_PW       = $clog2(CVB_MW);   // leading-one position
    localparam int CVB_SW       = 30;               // scaled magnitude, top in [2^29, 2^30)
    localparam int CVB_SQW      = 2 * CVB_SW + 2;   // sum of up to three squares
    localparam int CVB_RW       = CVB_SW + 1;       // square root width
    localparam int CVB_QW       = CVB_F + 1;        // quotient width, at most 2^F
    localparam int CVB_NW       = CVB_SW + CVB_F + 1;
    localparam int CVB_LANE_LAT = 5 + CVB_RW + CVB_QW;

    typedef struct packed {
        logic signed [CVB_CW-1:0] pos_x;
        logic signed [CVB_CW-1:0] pos_y;
        logic signed [CVB_CW-1:0] pos_z;
        logic signed [CVB_CW-1:0] look_x;
        logic signed [CVB_CW-1:0] look_y;
        logic signed [CVB_CW-1:0] look_z;
    } t_cvb_in;

    typedef struct packed {
        logic signed [CVB_OW-1:0] normal_x;
        logic signed [CVB_OW-1:0] normal_y;
        logic signed [CVB_OW-1:0] normal_z;
        logic signed [CVB_OW-1:0] side_x;
        logic signed [CVB_OW-1:0] side_y;
        logic signed [CVB_OW-1:0] side_z;
        logic signed [CVB_OW-1:0] upaxis_x;
        logic signed [CVB_OW-1:0] upaxis_y;
        logic signed [CVB_OW-1:0] upaxis_z;
        logic                     degenerate;
    } t_cvb_out;

    // Signs and degenerate flag carried alongside the normalising lanes
    typedef struct packed {
        logic degen;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } t_cvb_side;

endpackage

FILE: src/cvb_lane.sv
// Normalising lane: common shift, pipelined square root and pipelined divide.
module cvb_lane #(
    parameter int N = 3
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [N-1:0][cvb_pkg::CVB_MW-1:0]   i_mag,
    output logic [N-1:0][cvb_pkg::CVB_QW-1:0]   o_q
);

    localparam int MW  = cvb_pkg::CVB_MW;
    localparam int PW  = cvb_pkg::CVB_PW;
    localparam int SW  = cvb_pkg::CVB_SW;
    localparam int SQW = cvb_pkg::CVB_SQW;
    localparam int RW  = cvb_pkg::CVB_RW;
    localparam int QW  = cvb_pkg::CVB_QW;
    localparam int NW  = cvb_pkg::CVB_NW;
    localparam int F   = cvb_pkg::CVB_F;
    localparam int RMW = RW + 3;

    logic [MW-1:0]             w_or;
    logic [PW-1:0]             w_p;
    logic [N-1:0][MW-1:0]      r_m;
    logic [PW-1:0]             r_p;
    logic [N-1:0][SW-1:0]      r_s;
    logic [N-1:0][SW-1:0]      r_s2;
    logic [N-1:0][2*SW-1:0]    r_sq;
    logic [SQW-1:0]            n_sum;

    logic [RMW-1:0]            r_rem  [RW+1];
    logic [RW-1:0]             r_root [RW+1];
    logic [SQW-1:0]            r_x    [RW+1];
    logic [N-1:0][SW-1:0]      r_ms   [RW+1];

    logic [RW-1:0]             r_drem [QW+1][N];
    logic [QW-1:0]             r_lo   [QW+1][N];
    logic [QW-1:0]             r_q    [QW+1][N];
    logic [RW-1:0]             r_len  [QW+1];

    // Leading one of the OR is the leading one of the largest magnitude
    always_comb begin
        w_or = '0;
        w_p  = '0;
        for (int i = 0; i < N; i++) begin
            w_or = w_or | i_mag[i];
        end
        for (int b = 0; b < MW; b++) begin
            if (w_or[b]) begin
                w_p = PW'(b);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < N; i++) begin
            n_sum = n_sum + SQW'(r_sq[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= i_mag;
            r_p <= w_p;
            for (int i = 0; i < N; i++) begin
                // one right shift covers both directions: truncate above, exact below
                r_s[i]  <= SW'({r_m[i], {(SW-1){1'b0}}} >> r_p);
                r_sq[i] <= (2*SW)'(r_s[i]) * (2*SW)'(r_s[i]);
            end
            r_s2      <= r_s;
            r_x[0]    <= n_sum;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_ms[0]   <= r_s2;
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int J = RW - 1 - k;
        logic [RMW-1:0] w_sh;
        logic [RMW-1:0] w_t;

        assign w_sh = {r_rem[k][RMW-3:0], r_x[k][2*J+1 -: 2]};
        assign w_t  = RMW'({r_root[k], 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_sh >= w_t) begin
                    r_rem[k+1]  <= w_sh - w_t;
                    r_root[k+1] <= {r_root[k][RW-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= w_sh;
                    r_root[k+1] <= {r_root[k][RW-2:0], 1'b0};
                end
                r_x[k+1]  <= r_x[k];
                r_ms[k+1] <= r_ms[k];
            end
        end
    end

    // Rounded numerator, then restoring division one quotient bit per stage
    for (genvar i = 0; i < N; i++) begin : g_num
        logic [NW-1:0] w_num;

        assign w_num = NW'({r_ms[RW][i], {F{1'b0}}}) + NW'(r_root[RW] >> 1);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[0][i] <= RW'(w_num[NW-1:QW]);
                r_lo[0][i]   <= w_num[QW-1:0];
                r_q[0][i]    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= r_root[RW];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        for (genvar i = 0; i < N; i++) begin : g_comp
            logic [RW:0] w_t;

            assign w_t = {r_drem[k][i], r_lo[k][i][QW-1-k]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_t >= {1'b0, r_len[k]}) begin
                        r_drem[k+1][i] <= RW'(w_t - {1'b0, r_len[k]});
                        r_q[k+1][i]    <= {r_q[k][i][QW-2:0], 1'b1};
                    end else begin
                        r_drem[k+1][i] <= RW'(w_t);
                        r_q[k+1][i]    <= {r_q[k][i][QW-2:0], 1'b0};
                    end
                    r_lo[k+1][i] <= r_lo[k][i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k+1] <= r_len[k];
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_out
        assign o_q[i] = r_q[QW][i];
    end

endmodule

FILE: src/camera_view_basis_core.sv
// Top level of the look-at camera basis pipeline.
// Takes one camera pose (eye and look-at point, Q16.16) per cycle and returns the view
// normal, side axis and new up axis as Q1.15 unit vectors, with +1.0 held at 32767. Each
// request forms its direction, passes the two normalising lanes (shift, squares, a 31-stage
// square root and a 16-stage divider) and then registers for sign, the cross products and
// rounding. One request enters every cycle; a stall at the output freezes the whole
// pipeline. When the eye sits on the look-at point, or the view is straight up or down,
// degenerate is raised and all vectors read zero.
module camera_view_basis_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cvb_pkg::t_cvb_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cvb_pkg::t_cvb_out  o_out_data
);

    localparam int CW  = cvb_pkg::CVB_CW;
    localparam int F   = cvb_pkg::CVB_F;
    localparam int OW  = cvb_pkg::CVB_OW;
    localparam int MW  = cvb_pkg::CVB_MW;
    localparam int QW  = cvb_pkg::CVB_QW;
    localparam int LL  = cvb_pkg::CVB_LANE_LAT;
    localparam int LAT = LL + 4;
    localparam int PRW = 2 * OW;
    localparam int XW  = PRW + 1;

    logic                       w_en;
    logic [LAT-1:0]             r_vld;

    logic signed [CW:0]         r_d [3];
    logic                       r_degen;
    logic [2:0][MW-1:0]         w_mag_n;
    logic [1:0][MW-1:0]         w_mag_u;
    logic [2:0][QW-1:0]         w_q_n;
    logic [1:0][QW-1:0]         w_q_u;
    cvb_pkg::t_cvb_side         r_side [1:LL];

    logic signed [OW-1:0]       r_n [3];
    logic signed [OW-1:0]       r_u0;
    logic signed [OW-1:0]       r_u2;
    logic                       r_dg_s;
    logic signed [OW-1:0]       r_nm [3];
    logic signed [OW-1:0]       r_u0m;
    logic signed [OW-1:0]       r_u2m;
    logic                       r_dg_m;
    logic signed [PRW-1:0]      r_p12;
    logic signed [PRW-1:0]      r_p20;
    logic signed [PRW-1:0]      r_p02;
    logic signed [PRW-1:0]      r_p10;
    cvb_pkg::t_cvb_out          n_out;
    cvb_pkg::t_cvb_out          r_out;

    function automatic logic [MW-1:0] f_mag(input logic signed [CW:0] v);
        logic signed [CW:0] a;
        begin
            a = v[CW] ? -v : v;
            return MW'(a);
        end
    endfunction

    // Apply sign; only a positive quotient of exactly one overflows and saturates
    function automatic logic signed [OW-1:0] f_unit(input logic [QW-1:0] q, input logic neg);
        logic signed [OW:0] s;
        begin
            s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (s > $signed((OW+1)'((1 << F) - 1))) begin
                s = $signed((OW+1)'((1 << F) - 1));
            end
            return OW'(s);
        end
    endfunction

    // Round a Q2.2F value to Q1.F, halves upward, then saturate
    function automatic logic signed [OW-1:0] f_round(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] y;
        begin
            y = (x + $signed(XW'(1 << (F - 1)))) >>> F;
            if (y > $signed(XW'((1 << F) - 1))) begin
                y = $signed(XW'((1 << F) - 1));
            end else if (y < -$signed(XW'(1 << F))) begin
                y = -$signed(XW'(1 << F));
            end
            return OW'(y);
        end
    endfunction

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Exact direction, one bit wider than the coordinates
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0]  <= (CW+1)'(i_in_data.look_x) - (CW+1)'(i_in_data.pos_x);
            r_d[1]  <= (CW+1)'(i_in_data.look_y) - (CW+1)'(i_in_data.pos_y);
            r_d[2]  <= (CW+1)'(i_in_data.look_z) - (CW+1)'(i_in_data.pos_z);
            r_degen <= (i_in_data.look_x == i_in_data.pos_x)
                    && (i_in_data.look_z == i_in_data.pos_z);
        end
    end

    assign w_mag_n[0] = f_mag(r_d[0]);
    assign w_mag_n[1] = f_mag(r_d[1]);
    assign w_mag_n[2] = f_mag(r_d[2]);
    assign w_mag_u[0] = w_mag_n[2];
    assign w_mag_u[1] = w_mag_n[0];

    cvb_lane #(.N(3)) u_lane_n (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (w_mag_n),
        .o_q   (w_q_n)
    );

    cvb_lane #(.N(2)) u_lane_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (w_mag_u),
        .o_q   (w_q_u)
    );

    // Hold signs and the flag in step with the lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[1] <= '{degen: r_degen, neg_x: r_d[0][CW], neg_y: r_d[1][CW],
                           neg_z: r_d[2][CW]};
            for (int k = 2; k <= LL; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n[0] <= f_unit(w_q_n[0], r_side[LL].neg_x);
            r_n[1] <= f_unit(w_q_n[1], r_side[LL].neg_y);
            r_n[2] <= f_unit(w_q_n[2], r_side[LL].neg_z);
            r_u0   <= f_unit(w_q_u[0], r_side[LL].neg_z);
            // side z is -dx: negative when dx is positive; a zero dx gives zero anyway
            r_u2   <= f_unit(w_q_u[1], !r_side[LL].neg_x);
            r_dg_s <= r_side[LL].degen;

            r_p12  <= PRW'(r_n[1]) * PRW'(r_u2);
            r_p20  <= PRW'(r_n[2]) * PRW'(r_u0);
            r_p02  <= PRW'(r_n[0]) * PRW'(r_u2);
            r_p10  <= PRW'(r_n[1]) * PRW'(r_u0);
            r_nm   <= r_n;
            r_u0m  <= r_u0;
            r_u2m  <= r_u2;
            r_dg_m <= r_dg_s;

            r_out  <= n_out;
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.degenerate = r_dg_m;
        if (!r_dg_m) begin
            n_out.normal_x = r_nm[0];
            n_out.normal_y = r_nm[1];
            n_out.normal_z = r_nm[2];
            n_out.side_x   = r_u0m;
            n_out.side_y   = '0;
            n_out.side_z   = r_u2m;
            n_out.upaxis_x = f_round(XW'(r_p12));
            n_out.upaxis_y = f_round(XW'(r_p20) - XW'(r_p02));
            n_out.upaxis_z = f_round(-XW'(r_p10));
        end
    end

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.normal_x == 0 && o_out_data.normal_y == 0 &&
            o_out_data.normal_z == 0 && o_out_data.side_x == 0 &&
            o_out_data.side_z == 0 && o_out_data.upaxis_x == 0 &&
            o_out_data.upaxis_y == 0 && o_out_data.upaxis_z == 0)
        else $error("degenerate result carries nonzero vectors");

    a_side_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.side_y == 0)
        else $error("side axis has a y component");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while pipeline is stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

endmodule

FILE: dv/cvb_checker.sv
// Checker for the camera view basis core: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module cvb_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  cvb_pkg::t_cvb_in     i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  cvb_pkg::t_cvb_out    i_out_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam longint UNIT = longint'(1) << cvb_pkg::CVB_F;
    localparam int     F    = cvb_pkg::CVB_F;
    localparam int     OW   = cvb_pkg::CVB_OW;

    cvb_pkg::t_cvb_out basis_q[$];

    function automatic longint clamp_unit(longint v);
        if (v > UNIT - 1) return UNIT - 1;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    // Common power-of-two shift: largest magnitude into [2^29, 2^30)
    function automatic void normalise_mags(ref longint unsigned m[3], input int cnt);
        longint unsigned top;
        int rs;
        int ls;
        top = 0;
        rs = 0;
        ls = 0;
        for (int i = 0; i < cnt; i++) if (m[i] > top) top = m[i];
        if (top == 0) return;
        while (top >= (64'd1 << 30)) begin
            top >>= 1;
            rs++;
        end
        while (top < (64'd1 << 29)) begin
            top <<= 1;
            ls++;
        end
        for (int i = 0; i < cnt; i++) m[i] = (m[i] >> rs) << ls;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unit_div(longint unsigned mag, bit neg, longint unsigned len);
        longint q;
        q = longint'(((mag << F) + (len >> 1)) / len);
        return clamp_unit(neg ? -q : q);
    endfunction

    // Add half, floor shift (arithmetic shift is a floor)
    function automatic longint round_q(longint x);
        return clamp_unit((x + (longint'(1) << (F - 1))) >>> F);
    endfunction

    function automatic longint unsigned absv(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic cvb_pkg::t_cvb_out predict_basis(cvb_pkg::t_cvb_in p);
        cvb_pkg::t_cvb_out r;
        longint d[3];
        longint n[3];
        longint u[3];
        longint v[3];
        longint unsigned m[3];
        longint unsigned s[3];
        longint unsigned len;
        d[0] = longint'(p.look_x) - longint'(p.pos_x);
        d[1] = longint'(p.look_y) - longint'(p.pos_y);
        d[2] = longint'(p.look_z) - longint'(p.pos_z);
        r = '0;
        if (d[0] == 0 && d[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) m[i] = absv(d[i]);
        normalise_mags(m, 3);
        len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) n[i] = unit_div(m[i], d[i] < 0, len);
        s[0] = absv(d[2]);
        s[1] = absv(d[0]);
        s[2] = 0;
        normalise_mags(s, 2);
        len = floor_sqrt(s[0] * s[0] + s[1] * s[1]);
        u[0] = unit_div(s[0], d[2] < 0, len);
        u[1] = 0;
        u[2] = unit_div(s[1], d[0] > 0, len);
        v[0] = round_q(n[1] * u[2] - n[2] * u[1]);
        v[1] = round_q(n[2] * u[0] - n[0] * u[2]);
        v[2] = round_q(n[0] * u[1] - n[1] * u[0]);
        r.normal_x = n[0][OW-1:0];
        r.normal_y = n[1][OW-1:0];
        r.normal_z = n[2][OW-1:0];
        r.side_x   = u[0][OW-1:0];
        r.side_y   = u[1][OW-1:0];
        r.side_z   = u[2][OW-1:0];
        r.upaxis_x = v[0][OW-1:0];
        r.upaxis_y = v[1][OW-1:0];
        r.upaxis_z = v[2][OW-1:0];
        return r;
    endfunction

    task automatic compare_field(string nm, longint e, longint a);
        if (e != a) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, nm, e, a);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    assign o_pending = basis_q.size();

    always @(posedge i_clk) begin
        cvb_pkg::t_cvb_out e;
        cvb_pkg::t_cvb_out a;
        if (i_rst_n && i_in_valid && i_in_ready) basis_q.push_back(predict_basis(i_in_data));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            a = i_out_data;
            if (basis_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, a);
                o_errors++;
            end else begin
                e = basis_q.pop_front();
                compare_field("normal_x", e.normal_x, a.normal_x);
                compare_field("normal_y", e.normal_y, a.normal_y);
                compare_field("normal_z", e.normal_z, a.normal_z);
                compare_field("side_x", e.side_x, a.side_x);
                compare_field("side_y", e.side_y, a.side_y);
                compare_field("side_z", e.side_z, a.side_z);
                compare_field("upaxis_x", e.upaxis_x, a.upaxis_x);
                compare_field("upaxis_y", e.upaxis_y, a.upaxis_y);
                compare_field("upaxis_z", e.upaxis_z, a.upaxis_z);
                compare_field("degenerate", e.degenerate, a.degenerate);
            end
        end
    end
endmodule

FILE: dv/tb_top.sv
// Testbench top for the camera view basis core: stimulus, idling phases and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam int N_RANDOM = 2000;
    localparam int LATENCY  = 56;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    cvb_pkg::t_cvb_in   in_data;
    logic               out_valid;
    logic               out_ready;
    cvb_pkg::t_cvb_out  out_data;
    int                 errors;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_off;
    bit                 stim_done;

    camera_view_basis_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    cvb_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
        endcase
    endfunction

    function automatic cvb_pkg::t_cvb_in rand_pose();
        cvb_pkg::t_cvb_in p;
        p.pos_x  = rand_coord();
        p.pos_y  = rand_coord();
        p.pos_z  = rand_coord();
        p.look_x = rand_coord();
        p.look_y = rand_coord();
        p.look_z = rand_coord();
        // Nudge some poses onto the degenerate and near-axis cases
        case ($urandom_range(0, 19))
            0: p.look_x = p.pos_x;
            1: begin
                p.look_x = p.pos_x;
                p.look_z = p.pos_z;
            end
            2: p.look_z = p.pos_z;
            3: begin
                p.look_x = p.pos_x + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
                p.look_z = p.pos_z;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pose(cvb_pkg::t_cvb_in p);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic send_pair(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] lx, logic [31:0] ly, logic [31:0] lz);
        cvb_pkg::t_cvb_in p;
        p = '{px, py, pz, lx, ly, lz};
        send_pose(p);
    endtask

    // Receiver: random stalls, or a long hold-off while the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    initial begin
        int idle_mode;
        in_valid       = 1'b0;
        in_data        = '0;
        i_rst_n        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        stim_done      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed poses: extremes, degenerate and axis-aligned views
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 32'h0001_0000, 0);
        send_pair(0, 0, 0, 0, 32'hffff_0000, 0);
        send_pair(0, 0, 0, 32'h0001_0000, 0, 0);
        send_pair(0, 0, 0, 32'hffff_0000, 0, 0);
        send_pair(0, 0, 0, 0, 0, 32'h0001_0000);
        send_pair(0, 0, 0, 0, 0, 32'hffff_0000);
        send_pair(0, 0, 0, 1, 0, 0);
        send_pair(0, 0, 0, 1, 1, 1);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000);
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0);
        send_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                  32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        send_pair(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000);

        // Long output hold-off so the pipeline fills and stalls its input
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 120; k++) send_pose(rand_pose());
        join

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 250 == 0) begin
                idle_mode = (i / 250) % 4;
                send_idle_pct  = (idle_mode == 1 || idle_mode == 3) ?
                                 (idle_mode == 1 ? 68 : 14) : 0;
                recv_stall_pct = (idle_mode == 2 || idle_mode == 3) ?
                                 (idle_mode == 2 ? 68 : 14) : 0;
            end
            send_pose(rand_pose());
        end
        in_valid       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        stim_done = 1'b1;
        if (errors == 0) begin
            $display("PASS camera_view_basis_core");
        end else begin
            $display("FAIL camera_view_basis_core");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        if (!stim_done) begin
            $display("FAIL camera_view_basis_core");
            $finish;
        end
    end
endmodule
